[sv/ate_pkg.sv]
// package for the affine transform engine
// operation codes, sequencer states, fixed-point widths; no dependencies
package ate_pkg;

    localparam int DataW = 32;
    localparam int AccW  = 68;

    typedef enum logic [2:0] {
        FN_LOAD      = 3'd0,
        FN_READ      = 3'd1,
        FN_POINT     = 3'd2,
        FN_TRANSLATE = 3'd3,
        FN_SCALE     = 3'd4,
        FN_ROTATE    = 3'd5,
        FN_INVERSE   = 3'd6,
        FN_NOP       = 3'd7
    } func_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_QUAT = 6'b000010,
        ST_ROT  = 6'b000100,
        ST_MAC  = 6'b001000,
        ST_SAVE = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

[sv/affine_transform_engine.sv]
// affine transform engine top level: 3x4 matrix, one shared 32x32 multiplier
// depends on ate_pkg
// steps per beat: load/read/nop go straight to the result; point, translate, scale,
// inverse: 9 products, save, result; rotate: 9 quaternion products, rotation
// setup, 27 row products, save, result; result held valid until taken, then idle
// one beat in flight, s_axis_tready low until result taken; sync reset to identity
module affine_transform_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[2:0], index[6:3], in_x[38:7], in_y[70:39], in_z[102:71], in_w[134:103], zero fill
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], overflow[96], zero fill
    output logic [103:0] m_axis_tdata
);

    localparam int W = ate_pkg::DataW;
    localparam int A = ate_pkg::AccW;
    localparam logic signed [A-1:0] SMAX = A'(64'sh7fffffff);
    localparam logic signed [A-1:0] SMIN = -A'(64'sh80000000);
    localparam logic signed [A-1:0] ONE  = A'(1) <<< FRAC_BITS;

    ate_pkg::state_t state_reg, state_next;
    logic [2:0]  func_reg;
    logic signed [W-1:0] vec_reg [4];
    logic signed [W-1:0] mat_reg [12];
    logic signed [W-1:0] rot_reg [9];
    logic signed [W-1:0] res_reg [3];
    logic signed [A-1:0] acc_reg;
    logic [3:0]  row_reg;   // output element or quaternion term
    logic [1:0]  k_reg;
    logic        ov_reg;
    logic signed [W-1:0] nm_reg [9];

    // operand select
    logic signed [W-1:0] op_a, op_b;
    logic signed [2*W-1:0] prod;
    logic signed [A-1:0] rnd, sum, sat_in, satv;
    logic        sat_ov;
    logic [3:0]  r_i, r_j;
    logic [1:0]  nk;

    always_comb begin
        unique case (row_reg) inside
            [4'd0:4'd2]: r_i = 4'd0;
            [4'd3:4'd5]: r_i = 4'd1;
            default:     r_i = 4'd2;
        endcase
    end

    assign r_j = row_reg - r_i * 4'd3;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (ate_pkg::func_t'(func_reg)) inside
            ate_pkg::FN_POINT, ate_pkg::FN_TRANSLATE: begin
                op_a = vec_reg[k_reg];
                op_b = mat_reg[4'(k_reg) * 4'd3 + r_j];
            end
            ate_pkg::FN_SCALE: begin
                op_a = mat_reg[row_reg];
                op_b = vec_reg[r_i[1:0]];
            end
            ate_pkg::FN_INVERSE: begin
                op_a = mat_reg[r_j * 4'd3 + 4'(k_reg)];
                op_b = mat_reg[4'd9 + 4'(k_reg)];
            end
            ate_pkg::FN_ROTATE: begin
                if (state_reg == ate_pkg::ST_QUAT) begin
                    // xx xy xz yy yz zz xw yw zw
                    case (row_reg)
                        4'd0: begin op_a = vec_reg[0]; op_b = vec_reg[0]; end
                        4'd1: begin op_a = vec_reg[0]; op_b = vec_reg[1]; end
                        4'd2: begin op_a = vec_reg[0]; op_b = vec_reg[2]; end
                        4'd3: begin op_a = vec_reg[1]; op_b = vec_reg[1]; end
                        4'd4: begin op_a = vec_reg[1]; op_b = vec_reg[2]; end
                        4'd5: begin op_a = vec_reg[2]; op_b = vec_reg[2]; end
                        4'd6: begin op_a = vec_reg[3]; op_b = vec_reg[0]; end
                        4'd7: begin op_a = vec_reg[3]; op_b = vec_reg[1]; end
                        default: begin op_a = vec_reg[3]; op_b = vec_reg[2]; end
                    endcase
                end else begin
                    op_a = rot_reg[r_i * 4'd3 + 4'(k_reg)];
                    op_b = mat_reg[4'(k_reg) * 4'd3 + r_j];
                end
            end
            default: ;
        endcase
    end

    assign prod = op_a * op_b;

    always_comb begin
        if (state_reg == ate_pkg::ST_QUAT)
            rnd = (A'(prod) + (A'(1) <<< (FRAC_BITS - 2))) >>> (FRAC_BITS - 1);
        else
            rnd = (A'(prod) + (A'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end

    assign sum = acc_reg + rnd;

    // inverse negates the full sum before saturation
    assign sat_in = (func_reg == ate_pkg::FN_INVERSE) ? -sum : sum;

    always_comb begin
        sat_ov = 1'b0;
        satv = sat_in;
        if (sat_in > SMAX) begin
            satv = SMAX;
            sat_ov = 1'b1;
        end else if (sat_in < SMIN) begin
            satv = SMIN;
            sat_ov = 1'b1;
        end
    end

    // quaternion terms held at accumulator width then formed into rotation elements
    logic signed [A-1:0] q_reg [9];
    logic signed [A-1:0] relem [9];
    logic [8:0] rov;
    always_comb begin
        relem[0] = ONE - (q_reg[3] + q_reg[5]);
        relem[1] = q_reg[1] + q_reg[8];
        relem[2] = q_reg[2] - q_reg[7];
        relem[3] = q_reg[1] - q_reg[8];
        relem[4] = ONE - (q_reg[0] + q_reg[5]);
        relem[5] = q_reg[4] + q_reg[6];
        relem[6] = q_reg[2] + q_reg[7];
        relem[7] = q_reg[4] - q_reg[6];
        relem[8] = ONE - (q_reg[0] + q_reg[3]);
        for (int n = 0; n < 9; n++)
            rov[n] = (relem[n] > SMAX) || (relem[n] < SMIN);
    end

    assign nk = k_reg + 2'd1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ate_pkg::ST_IDLE: if (s_axis_tvalid) begin
                unique case (ate_pkg::func_t'(s_axis_tdata[2:0])) inside
                    ate_pkg::FN_ROTATE: state_next = ate_pkg::ST_QUAT;
                    ate_pkg::FN_POINT, ate_pkg::FN_TRANSLATE, ate_pkg::FN_SCALE,
                    ate_pkg::FN_INVERSE: state_next = ate_pkg::ST_MAC;
                    default: state_next = ate_pkg::ST_OUT;
                endcase
            end
            ate_pkg::ST_QUAT: if (row_reg == 4'd8) state_next = ate_pkg::ST_ROT;
            ate_pkg::ST_ROT: state_next = ate_pkg::ST_MAC;
            ate_pkg::ST_MAC: begin
                if (func_reg == ate_pkg::FN_SCALE) begin
                    if (row_reg == 4'd8) state_next = ate_pkg::ST_SAVE;
                end else if (k_reg == 2'd2 && ((func_reg == ate_pkg::FN_ROTATE &&
                             row_reg == 4'd8) || (func_reg != ate_pkg::FN_ROTATE &&
                             row_reg == 4'd2)))
                    state_next = ate_pkg::ST_SAVE;
            end
            ate_pkg::ST_SAVE: state_next = ate_pkg::ST_OUT;
            ate_pkg::ST_OUT: if (m_axis_tready) state_next = ate_pkg::ST_IDLE;
            default: state_next = ate_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ate_pkg::ST_IDLE;
            for (int n = 0; n < 12; n++)
                mat_reg[n] <= (n == 0 || n == 4 || n == 8) ? W'(ONE) : '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ate_pkg::ST_IDLE: if (s_axis_tvalid) begin
                    func_reg   <= s_axis_tdata[2:0];
                    vec_reg[0] <= s_axis_tdata[38:7];
                    vec_reg[1] <= s_axis_tdata[70:39];
                    vec_reg[2] <= s_axis_tdata[102:71];
                    vec_reg[3] <= s_axis_tdata[134:103];
                    row_reg <= '0;
                    k_reg   <= '0;
                    ov_reg  <= 1'b0;
                    res_reg[0] <= (s_axis_tdata[2:0] == ate_pkg::FN_READ &&
                                   s_axis_tdata[6:3] < 4'd12) ?
                                  mat_reg[s_axis_tdata[6:3]] : '0;
                    res_reg[1] <= '0;
                    res_reg[2] <= '0;
                    acc_reg <= (s_axis_tdata[2:0] == ate_pkg::FN_TRANSLATE) ?
                               A'(mat_reg[9]) :
                               (s_axis_tdata[2:0] == ate_pkg::FN_POINT) ?
                               A'(mat_reg[9]) : '0;
                    unique case (ate_pkg::func_t'(s_axis_tdata[2:0]))
                        ate_pkg::FN_LOAD:
                            if (s_axis_tdata[6:3] < 4'd12)
                                mat_reg[s_axis_tdata[6:3]] <= s_axis_tdata[38:7];
                        default: ;
                    endcase
                end
                ate_pkg::ST_QUAT: begin
                    q_reg[row_reg] <= rnd;
                    row_reg <= row_reg + 4'd1;
                end
                ate_pkg::ST_ROT: begin
                    for (int n = 0; n < 9; n++)
                        rot_reg[n] <= W'(relem[n] > SMAX ? SMAX :
                                         relem[n] < SMIN ? SMIN : relem[n]);
                    if (|rov) ov_reg <= 1'b1;
                    row_reg <= '0;
                    k_reg   <= '0;
                    acc_reg <= '0;
                end
                ate_pkg::ST_MAC: begin
                    if (func_reg == ate_pkg::FN_SCALE) begin
                        nm_reg[row_reg] <= W'(satv);
                        if (sat_ov) ov_reg <= 1'b1;
                        row_reg <= row_reg + 4'd1;
                    end else if (k_reg != 2'd2) begin
                        acc_reg <= sum;
                        k_reg <= nk;
                    end else begin
                        k_reg <= '0;
                        if (sat_ov) ov_reg <= 1'b1;
                        nm_reg[row_reg] <= W'(satv);
                        acc_reg <= ((func_reg == ate_pkg::FN_POINT ||
                                     func_reg == ate_pkg::FN_TRANSLATE) &&
                                    row_reg != 4'd2) ?
                                   A'(mat_reg[4'd10 + row_reg]) : '0;
                        row_reg <= row_reg + 4'd1;
                    end
                end
                ate_pkg::ST_SAVE: begin
                    unique case (ate_pkg::func_t'(func_reg))
                        ate_pkg::FN_POINT: begin
                            for (int n = 0; n < 3; n++)
                                res_reg[n] <= nm_reg[n];
                        end
                        ate_pkg::FN_TRANSLATE: begin
                            for (int n = 0; n < 3; n++)
                                mat_reg[9 + n] <= nm_reg[n];
                        end
                        ate_pkg::FN_SCALE, ate_pkg::FN_ROTATE: begin
                            for (int n = 0; n < 9; n++)
                                mat_reg[n] <= nm_reg[n];
                        end
                        ate_pkg::FN_INVERSE: begin
                            for (int n = 0; n < 3; n++) begin
                                mat_reg[9 + n] <= nm_reg[n];
                                for (int m = 0; m < 3; m++)
                                    mat_reg[3 * n + m] <= mat_reg[3 * m + n];
                            end
                        end
                        default: ;
                    endcase
                end
                ate_pkg::ST_OUT: ;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ate_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == ate_pkg::ST_OUT);
    assign m_axis_tdata  = {7'd0, ov_reg, res_reg[2], res_reg[1], res_reg[0]};

endmodule

[tb/affine_transform_engine_checker.sv]
// result checker for the affine transform engine: watches both stream channels,
// predicts each result from its own copy of the matrix and compares it
// depends on ate_pkg
module affine_transform_engine_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic        overflow;
        logic [31:0] out_z;
        logic [31:0] out_y;
        logic [31:0] out_x;
    } result_t;

    localparam longint S32Max = 64'sd2147483647;
    localparam longint S32Min = -64'sd2147483648;
    localparam longint OneFx  = longint'(1) <<< FRAC_BITS;

    logic signed [31:0] mat [12];
    result_t expected_results [$];

    function automatic longint rnd_mul(longint a, longint b, int frac);
        return (a * b + (longint'(1) <<< (frac - 1))) >>> frac;
    endfunction

    function automatic logic signed [31:0] clamp(longint v, ref logic ov);
        if (v > S32Max) begin
            ov = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < S32Min) begin
            ov = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic result_t apply_op(logic [135:0] d);
        ate_pkg::func_t fn;
        logic [3:0] idx;
        longint vx, vy, vz, vw;
        longint xx, xy, xz, yy, yz, zz, xw, yw, zw;
        logic signed [31:0] nm [12];
        logic signed [31:0] rm [9];
        logic ov;
        result_t r;
        fn  = ate_pkg::func_t'(d[2:0]);
        idx = d[6:3];
        vx  = longint'($signed(d[38:7]));
        vy  = longint'($signed(d[70:39]));
        vz  = longint'($signed(d[102:71]));
        vw  = longint'($signed(d[134:103]));
        ov  = 1'b0;
        r   = '0;
        case (fn)
            ate_pkg::FN_LOAD: if (idx < 12) mat[idx] = vx[31:0];
            ate_pkg::FN_READ: if (idx < 12) r.out_x = mat[idx];
            ate_pkg::FN_POINT: begin
                for (int j = 0; j < 3; j++)
                    nm[j] = clamp(rnd_mul(vx, mat[j], FRAC_BITS)
                        + rnd_mul(vy, mat[3+j], FRAC_BITS)
                        + rnd_mul(vz, mat[6+j], FRAC_BITS) + longint'(mat[9+j]), ov);
                r.out_x = nm[0];
                r.out_y = nm[1];
                r.out_z = nm[2];
            end
            ate_pkg::FN_TRANSLATE: begin
                for (int j = 0; j < 3; j++)
                    nm[j] = clamp(longint'(mat[9+j]) + rnd_mul(mat[j], vx, FRAC_BITS)
                        + rnd_mul(mat[3+j], vy, FRAC_BITS)
                        + rnd_mul(mat[6+j], vz, FRAC_BITS), ov);
                for (int j = 0; j < 3; j++) mat[9+j] = nm[j];
            end
            ate_pkg::FN_SCALE: begin
                for (int j = 0; j < 3; j++) begin
                    mat[j]   = clamp(rnd_mul(mat[j], vx, FRAC_BITS), ov);
                    mat[3+j] = clamp(rnd_mul(mat[3+j], vy, FRAC_BITS), ov);
                    mat[6+j] = clamp(rnd_mul(mat[6+j], vz, FRAC_BITS), ov);
                end
            end
            ate_pkg::FN_ROTATE: begin
                xx = rnd_mul(vx, vx, FRAC_BITS-1); xy = rnd_mul(vx, vy, FRAC_BITS-1);
                xz = rnd_mul(vx, vz, FRAC_BITS-1); yy = rnd_mul(vy, vy, FRAC_BITS-1);
                yz = rnd_mul(vy, vz, FRAC_BITS-1); zz = rnd_mul(vz, vz, FRAC_BITS-1);
                xw = rnd_mul(vw, vx, FRAC_BITS-1); yw = rnd_mul(vw, vy, FRAC_BITS-1);
                zw = rnd_mul(vw, vz, FRAC_BITS-1);
                rm[0] = clamp(OneFx - (yy + zz), ov);
                rm[1] = clamp(xy + zw, ov);
                rm[2] = clamp(xz - yw, ov);
                rm[3] = clamp(xy - zw, ov);
                rm[4] = clamp(OneFx - (xx + zz), ov);
                rm[5] = clamp(yz + xw, ov);
                rm[6] = clamp(xz + yw, ov);
                rm[7] = clamp(yz - xw, ov);
                rm[8] = clamp(OneFx - (xx + yy), ov);
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        nm[3*i+j] = clamp(rnd_mul(rm[3*i], mat[j], FRAC_BITS)
                            + rnd_mul(rm[3*i+1], mat[3+j], FRAC_BITS)
                            + rnd_mul(rm[3*i+2], mat[6+j], FRAC_BITS), ov);
                for (int i = 0; i < 9; i++) mat[i] = nm[i];
            end
            ate_pkg::FN_INVERSE: begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        nm[3*i+j] = mat[3*j+i];
                for (int j = 0; j < 3; j++)
                    nm[9+j] = clamp(-(rnd_mul(mat[3*j], mat[9], FRAC_BITS)
                        + rnd_mul(mat[3*j+1], mat[10], FRAC_BITS)
                        + rnd_mul(mat[3*j+2], mat[11], FRAC_BITS)), ov);
                for (int i = 0; i < 12; i++) mat[i] = nm[i];
            end
            default: ;
        endcase
        r.overflow = ov;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < 12; i++)
                mat[i] <= (i == 0 || i == 4 || i == 8) ? 32'(OneFx) : '0;
            expected_results.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_op(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[96:0];
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation: %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (got.out_x !== want.out_x)
                            $error("out_x expected %h actual %h", want.out_x, got.out_x);
                        if (got.out_y !== want.out_y)
                            $error("out_y expected %h actual %h", want.out_y, got.out_y);
                        if (got.out_z !== want.out_z)
                            $error("out_z expected %h actual %h", want.out_z, got.out_z);
                        if (got.overflow !== want.overflow)
                            $error("overflow expected %b actual %b",
                                want.overflow, got.overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

[tb/tb_affine_transform_engine.sv]
// testbench top for the affine transform engine: directed and random beats
// with bursty sender and stalling receiver; checks via the checker module
// depends on ate_pkg, affine_transform_engine, affine_transform_engine_checker
module tb_affine_transform_engine;

    localparam int NumRandom  = 1480;
    localparam int CycleLimit = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           cycle_count = 0;
    logic         hold_off = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    affine_transform_engine i_dut (.*);

    affine_transform_engine_checker i_checker (.*);

    function automatic logic [135:0] pack_beat(ate_pkg::func_t fn, logic [3:0] idx,
        logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
        return {1'b0, w, z, y, x, idx, fn};
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic send_beat(logic [135:0] d);
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_random();
        ate_pkg::func_t fn;
        logic [3:0] idx;
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) fn = ate_pkg::FN_LOAD;
        else if (r < 35) fn = ate_pkg::FN_READ;
        else if (r < 60) fn = ate_pkg::FN_POINT;
        else if (r < 70) fn = ate_pkg::FN_TRANSLATE;
        else if (r < 78) fn = ate_pkg::FN_SCALE;
        else if (r < 86) fn = ate_pkg::FN_ROTATE;
        else if (r < 94) fn = ate_pkg::FN_INVERSE;
        else fn = ate_pkg::FN_NOP;
        idx = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
        send_beat(pack_beat(fn, idx, rand_value(), rand_value(), rand_value(), rand_value()));
    endtask

    // receiver: own stall pattern, plus one long hold-off
    always @(posedge aclk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("FAIL affine_transform_engine");
            $finish;
        end
    end

    initial begin
        wait (cycle_count == 3000);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: each operation, extremes, out-of-range index, unused code
        send_beat(pack_beat(ate_pkg::FN_READ, 4'd0, '0, '0, '0, '0));
        send_beat(pack_beat(ate_pkg::FN_READ, 4'd15, '0, '0, '0, '0));
        send_beat(pack_beat(ate_pkg::FN_POINT, 4'd0, 32'h00018000, 32'hfffe0000,
            32'h00004000, '0));
        send_beat(pack_beat(ate_pkg::FN_POINT, 4'd0, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, '0));
        send_beat(pack_beat(ate_pkg::FN_LOAD, 4'd9, 32'h7fffffff, '0, '0, '0));
        send_beat(pack_beat(ate_pkg::FN_LOAD, 4'd12, 32'h12345678, '0, '0, '0));
        send_beat(pack_beat(ate_pkg::FN_LOAD, 4'd10, 32'h80000000, '0, '0, '0));
        send_beat(pack_beat(ate_pkg::FN_POINT, 4'd0, 32'h00010000, 32'hffff0000, '0, '0));
        send_beat(pack_beat(ate_pkg::FN_TRANSLATE, 4'd0, 32'h00010000, 32'hffff0000,
            32'h00020000, '0));
        send_beat(pack_beat(ate_pkg::FN_SCALE, 4'd0, 32'h00020000, 32'hffff8000,
            32'h7fffffff, '0));
        send_beat(pack_beat(ate_pkg::FN_ROTATE, 4'd0, 32'h00000000, 32'h00000000,
            32'h0000b505, 32'h0000b505));
        send_beat(pack_beat(ate_pkg::FN_ROTATE, 4'd0, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff));
        send_beat(pack_beat(ate_pkg::FN_INVERSE, 4'd0, '0, '0, '0, '0));
        send_beat(pack_beat(ate_pkg::FN_NOP, 4'd15, 32'hffffffff, 32'hffffffff,
            32'hffffffff, 32'hffffffff));
        for (int i = 0; i < 12; i++)
            send_beat(pack_beat(ate_pkg::FN_READ, 4'(i), '0, '0, '0, '0));
        for (int n = 0; n < NumRandom; n++) begin
            // occasionally restore a sane matrix so products stay in range
            if ($urandom_range(0, 59) == 0)
                for (int i = 0; i < 12; i++)
                    send_beat(pack_beat(ate_pkg::FN_LOAD, 4'(i),
                        (i % 4 == 0 && i < 9) ? 32'h00010000 : 32'($urandom_range(0, 65535)),
                        '0, '0, '0));
            send_random();
        end
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) $display("PASS affine_transform_engine");
        else $display("FAIL affine_transform_engine");
        $finish;
    end

endmodule
